>>> hdl/wpseq_pkg.sv
// ============================================================================
// Waypoint sequencer package
// Shared constants, input codes and register indexes of the waypoint
// sequencer with landing.
// ============================================================================
package wpseq_pkg;

    // Default sizes of the waypoint table and of one coordinate.
    localparam int DEF_MAX_WAYPOINTS = 64;
    localparam int DEF_COORD_BITS    = 24;

    // Configuration port geometry and register widths.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int RADIUS_W    = 16;
    localparam int ROUTE_LEN_W = 7;

    // Register reset values.
    localparam int ARRIVE_RADIUS_RST = 100;

    // Altitude commanded while landing, in millimetres.
    localparam int LAND_Z_MM = -200;

    // Kind of input beat.
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TICK = 1'b1
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARRIVE_RADIUS = 1'b0,
        CFG_ROUTE_LENGTH  = 1'b1
    } t_cfg_reg;

endpackage

>>> hdl/waypoint_sequencer_with_landing.sv
// ============================================================================
// Waypoint sequencer with landing
// Holds a waypoint table; each tick on an active route gives one position
// command, stepping along the route and landing after the last waypoint.
// ============================================================================
// Load beats write one waypoint into the table and are taken one per cycle.
// A tick beat is handled in steps: the table is read at the current and the
// following entry on acceptance, the per-axis distances are formed in the
// next cycle, then, once the output register is free or being read, the
// squared distance is compared with the squared radius and the waypoint index
// is written back. Since the next tick reads the table at that updated index,
// a new tick is accepted only once the previous one has left the pipeline,
// which takes longer while the output register is stalled. A finished result
// may wait in the output register while the next beat is accepted. The table
// has no reset and needs no clearing pass; entries must be loaded before the
// route uses them.
module waypoint_sequencer_with_landing #(
    parameter int MAX_WAYPOINTS = wpseq_pkg::DEF_MAX_WAYPOINTS,
    parameter int COORD_BITS    = wpseq_pkg::DEF_COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [wpseq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wpseq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0]     i_slot,
    input  logic signed [COORD_BITS-1:0]         i_coord_x,
    input  logic signed [COORD_BITS-1:0]         i_coord_y,
    input  logic signed [COORD_BITS-1:0]         i_coord_z,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [COORD_BITS-1:0]         o_cmd_x,
    output logic signed [COORD_BITS-1:0]         o_cmd_y,
    output logic signed [COORD_BITS-1:0]         o_cmd_z,
    output logic [$clog2(MAX_WAYPOINTS)-1:0]     o_target_index,
    output logic                                 o_route_done,
    output logic                                 o_landing
);
    import wpseq_pkg::*;

    localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
    localparam int MEM_W  = 3 * COORD_BITS;
    localparam int LEN_W  = (IDX_W + 1 > ROUTE_LEN_W) ? IDX_W + 1 : ROUTE_LEN_W;
    localparam int DIFF_W = (COORD_BITS + 1 > RADIUS_W + 1) ? COORD_BITS + 1
                                                            : RADIUS_W + 1;
    localparam int SQ_W   = 2 * RADIUS_W;
    localparam int SUM_W  = SQ_W + 2;

    localparam logic [SQ_W-1:0] RAD_SQ_RST =
        SQ_W'(ARRIVE_RADIUS_RST * ARRIVE_RADIUS_RST);
    localparam logic signed [COORD_BITS-1:0] LAND_Z = COORD_BITS'(LAND_Z_MM);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WAYPOINTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_WAYPOINTS - 1);

    // Waypoint table, packed as {z, y, x}.
    logic [MEM_W-1:0] r_table [MAX_WAYPOINTS];

    // Configuration registers.
    logic [SQ_W-1:0]        r_rad_sq;
    logic [ROUTE_LEN_W-1:0] r_route_len;

    // Route state.
    logic [IDX_W-1:0] r_cur_idx, n_cur_idx;
    logic             r_done, n_done;

    // Pipeline control and payload.
    logic                         r_s1_vld, r_s2_vld;
    logic [MEM_W-1:0]             r_rd_cur, r_rd_nxt;
    logic signed [COORD_BITS-1:0] r_s1_pos [3];
    logic [RADIUS_W-1:0]          r_s2_mag [3];
    logic                         r_s2_far;

    // Output register.
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_cmd [3];
    logic [IDX_W-1:0]             r_out_idx;
    logic                         r_out_done, r_out_land;

    logic                         w_busy, w_accept, w_load_acc, w_tick_acc;
    logic [IDX_W-1:0]             w_idx_nxt;
    logic signed [COORD_BITS-1:0] w_cur [3];
    logic signed [COORD_BITS-1:0] w_nxt [3];
    logic signed [DIFF_W-1:0]     w_diff [3];
    logic [DIFF_W-1:0]            w_mag [3];
    logic [SQ_W-1:0]              w_sq [3];
    logic [SUM_W-1:0]             w_sum;
    logic                         w_reached, w_fire, w_active, w_before_last;
    logic [LEN_W-1:0]             w_len, w_route_ext, w_idx_ext;
    logic signed [COORD_BITS-1:0] n_cmd [3];
    logic                         n_land;

    // Input handshake: loads always pass, a tick waits for the pipeline.
    assign w_busy     = r_s1_vld | r_s2_vld;
    assign o_in_ready = !w_busy || (i_mode == MODE_LOAD);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_load_acc = w_accept && (i_mode == MODE_LOAD);
    assign w_tick_acc = w_accept && (i_mode == MODE_TICK);
    assign w_idx_nxt  = (r_cur_idx == LAST_SLOT) ? '0 : r_cur_idx + 1'b1;

    // Configuration writes; the squared radius is kept ready for the compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_sq    <= RAD_SQ_RST;
            r_route_len <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_ARRIVE_RADIUS: begin
                    r_rad_sq <= SQ_W'(i_cfg_data[RADIUS_W-1:0])
                              * SQ_W'(i_cfg_data[RADIUS_W-1:0]);
                end
                CFG_ROUTE_LENGTH: begin
                    r_route_len <= i_cfg_data[ROUTE_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Table: one write port for loads, two registered read ports for ticks.
    always_ff @(posedge i_clk) begin
        if (w_load_acc && ({1'b0, i_slot} < (IDX_W + 1)'(MAX_WAYPOINTS))) begin
            r_table[i_slot] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        if (w_tick_acc) begin
            r_rd_cur <= r_table[r_cur_idx];
            r_rd_nxt <= r_table[w_idx_nxt];
        end
    end

    // The measured position travels alongside the table read.
    always_ff @(posedge i_clk) begin
        if (w_tick_acc) begin
            r_s1_pos[0] <= i_coord_x;
            r_s1_pos[1] <= i_coord_y;
            r_s1_pos[2] <= i_coord_z;
        end
    end

    // Per-axis absolute distance; anything above the radius range is far.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_cur[a]  = r_rd_cur[a*COORD_BITS +: COORD_BITS];
            w_nxt[a]  = r_rd_nxt[a*COORD_BITS +: COORD_BITS];
            w_diff[a] = DIFF_W'(r_s1_pos[a]) - DIFF_W'(w_cur[a]);
            w_mag[a]  = w_diff[a][DIFF_W-1] ? DIFF_W'(-w_diff[a])
                                            : DIFF_W'(w_diff[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            for (int a = 0; a < 3; a++) begin
                r_s2_mag[a] <= w_mag[a][RADIUS_W-1:0];
            end
            r_s2_far <= (|w_mag[0][DIFF_W-1:RADIUS_W])
                      | (|w_mag[1][DIFF_W-1:RADIUS_W])
                      | (|w_mag[2][DIFF_W-1:RADIUS_W]);
        end
    end

    // Squared distance against the squared radius.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sq[a] = SQ_W'(r_s2_mag[a]) * SQ_W'(r_s2_mag[a]);
        end
        w_sum     = SUM_W'(w_sq[0]) + SUM_W'(w_sq[1]) + SUM_W'(w_sq[2]);
        w_reached = !r_s2_far && (w_sum < SUM_W'(r_rad_sq));
    end

    // Route position: effective length, last waypoint and the tick's effect.
    always_comb begin
        w_route_ext   = LEN_W'(r_route_len);
        w_len         = (w_route_ext > MAX_LEN) ? MAX_LEN : w_route_ext;
        w_idx_ext     = LEN_W'(r_cur_idx);
        w_active      = (w_len != '0) && (w_idx_ext < w_len);
        w_before_last = (w_idx_ext + 1'b1) < w_len;
        w_fire        = r_s2_vld && (!r_out_valid || i_out_ready);

        n_cur_idx = r_cur_idx;
        n_done    = r_done;
        n_land    = 1'b0;
        n_cmd     = w_cur;
        if (w_before_last) begin
            if (w_reached) begin
                n_cur_idx = w_idx_nxt;
                n_cmd     = w_nxt;
            end
        end else if (r_done) begin
            n_cmd[2] = LAND_Z;
            n_land   = 1'b1;
        end else if (w_reached) begin
            n_done = 1'b1;
        end
    end

    // Pipeline control, route state and the output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_cur_idx   <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_vld <= w_tick_acc;
            if (r_s1_vld) begin
                r_s2_vld <= 1'b1;
            end else if (w_fire) begin
                r_s2_vld <= 1'b0;
            end
            if (w_fire && w_active) begin
                r_cur_idx   <= n_cur_idx;
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_active) begin
            r_cmd      <= n_cmd;
            r_out_idx  <= n_cur_idx;
            r_out_done <= n_done;
            r_out_land <= n_land;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd_x        = r_cmd[0];
    assign o_cmd_y        = r_cmd[1];
    assign o_cmd_z        = r_cmd[2];
    assign o_target_index = r_out_idx;
    assign o_route_done   = r_out_done;
    assign o_landing      = r_out_land;

    // At most one tick is in flight.
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_vld && r_s2_vld))
        else $error("two ticks in flight");

    // A tick moves from the read stage to the compare stage in the following cycle.
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |=> r_s2_vld)
        else $error("tick lost between stages");

    // The waypoint index only moves when a result is produced.
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fire && w_active) |=> $stable(r_cur_idx))
        else $error("waypoint index moved without a result");

    // The done flag is never withdrawn.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_done))
        else $error("done flag cleared");

    // A landing command is only given once the route is done.
    a_land_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_landing) |-> o_route_done)
        else $error("landing before route done");

endmodule

>>> tb/tb_top.sv
// ============================================================================
// Waypoint sequencer with landing: self-checking testbench
// Drives load and tick beats through the valid/ready input channel, keeps its
// own copy of the waypoint table, route index and done flag, and compares each
// position command that leaves the block with the predicted one, field by
// field. A directed opening covers the extremes and corner cases, then random
// phases with fresh register settings walk the route through to landing.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpseq_pkg::*;

    localparam int CW           = DEF_COORD_BITS;
    localparam int NWP          = DEF_MAX_WAYPOINTS;
    localparam int IW           = $clog2(NWP);
    localparam int RANDOM_BEATS = 765;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 600000;
    localparam int COORD_MAX    = 8388607;
    localparam int COORD_MIN    = -8388608;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_waypoint;

    typedef struct {
        t_waypoint       pos;
        logic [IW-1:0]   index;
        logic            done;
        logic            land;
    } t_route_cmd;

    // Where a generated tick is placed relative to the current target.
    typedef enum int {
        AIM_NEAR,
        AIM_EDGE_IN,
        AIM_EDGE_OUT,
        AIM_LOCAL,
        AIM_WILD
    } t_aim;

    // Tracks the route as the block should see it and queues the commands
    // that each tick must produce.
    class route_tracker;
        t_waypoint  wp_table [NWP];
        int         cur_idx;
        bit         done_flag;
        int         radius;
        int         route_len;
        t_route_cmd pending_cmds [$];
        int         errors;
        int         loads;
        int         ticks;
        int         checked;
        int         landings;

        function new();
            foreach (wp_table[i]) wp_table[i] = '0;
            cur_idx   = 0;
            done_flag = 0;
            radius    = ARRIVE_RADIUS_RST;
            route_len = 0;
            errors    = 0;
            loads     = 0;
            ticks     = 0;
            checked   = 0;
            landings  = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, int data);
            case (idx)
                CFG_ARRIVE_RADIUS: radius    = data & ((1 << RADIUS_W) - 1);
                CFG_ROUTE_LENGTH:  route_len = data & ((1 << ROUTE_LEN_W) - 1);
                default: ;
            endcase
        endfunction

        // Squared distance strictly below the squared radius; any axis beyond
        // 16 bits can never be inside.
        function bit reached(t_waypoint p, t_waypoint w);
            longint dx, dy, dz, r;
            dx = longint'(p.x) - longint'(w.x);
            dy = longint'(p.y) - longint'(w.y);
            dz = longint'(p.z) - longint'(w.z);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            r = radius;
            if (dx > 65535 || dy > 65535 || dz > 65535) return 0;
            return (dx * dx + dy * dy + dz * dz) < (r * r);
        endfunction

        function void note_beat(t_mode mode, logic [IW-1:0] slot, t_waypoint pos);
            int         len;
            t_route_cmd cmd;
            if (mode == MODE_LOAD) begin
                wp_table[slot] = pos;
                loads++;
                return;
            end
            ticks++;
            len = (route_len > NWP) ? NWP : route_len;
            // An empty route, or an index left beyond a shortened one, is silent.
            if (len == 0 || cur_idx >= len) return;
            cmd.land = 0;
            if (cur_idx < len - 1) begin
                if (reached(pos, wp_table[cur_idx])) cur_idx++;
                cmd.pos = wp_table[cur_idx];
            end else if (done_flag) begin
                cmd.pos   = wp_table[cur_idx];
                cmd.pos.z = CW'(LAND_Z_MM);
                cmd.land  = 1;
            end else begin
                cmd.pos = wp_table[cur_idx];
                if (reached(pos, wp_table[cur_idx])) done_flag = 1;
            end
            cmd.index = IW'(cur_idx);
            cmd.done  = done_flag;
            pending_cmds.push_back(cmd);
        endfunction

        function void check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_command(t_route_cmd got);
            t_route_cmd want;
            if (pending_cmds.size() == 0) begin
                $error("Command beat arrived with no command outstanding");
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            checked++;
            if (want.land) landings++;
            check_field("cmd_x", want.pos.x, got.pos.x);
            check_field("cmd_y", want.pos.y, got.pos.y);
            check_field("cmd_z", want.pos.z, got.pos.z);
            check_field("target_index", CW'(want.index), CW'(got.index));
            check_field("route_done", CW'(want.done), CW'(got.done));
            check_field("landing", CW'(want.land), CW'(got.land));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_mode;
    logic [IW-1:0]         i_slot;
    logic signed [CW-1:0]  i_coord_x;
    logic signed [CW-1:0]  i_coord_y;
    logic signed [CW-1:0]  i_coord_z;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic signed [CW-1:0]  o_cmd_x;
    logic signed [CW-1:0]  o_cmd_y;
    logic signed [CW-1:0]  o_cmd_z;
    logic [IW-1:0]         o_target_index;
    logic                  o_route_done;
    logic                  o_landing;

    route_tracker tracker = new();
    bit           tx_tight = 0;
    bit           rx_tight = 0;
    int           cycle_count = 0;

    waypoint_sequencer_with_landing dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cmd_x        (o_cmd_x),
        .o_cmd_y        (o_cmd_y),
        .o_cmd_z        (o_cmd_z),
        .o_target_index (o_target_index),
        .o_route_done   (o_route_done),
        .o_landing      (o_landing)
    );

    always #5 i_clk = ~i_clk;

    // Run length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("Timed out after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // Every command beat that the block hands over is checked here.
    always @(posedge i_clk) begin : cmd_monitor
        t_route_cmd got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.pos.x = o_cmd_x;
            got.pos.y = o_cmd_y;
            got.pos.z = o_cmd_z;
            got.index = o_target_index;
            got.done  = o_route_done;
            got.land  = o_landing;
            tracker.check_command(got);
        end
    end

    // Mostly short gaps, now and then a long one, none at all when tight.
    function automatic int idle_span(bit tight);
        int r;
        if (tight) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The receiver stalls at random and, once, holds off for a long stretch
    // so that the block fills up and stalls its input.
    initial begin : cmd_sink
        int stall_left;
        int span;
        bit held;
        stall_left = 0;
        held       = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (!held && tracker.checked >= 200) begin
                held        = 1;
                i_out_ready = 1'b0;
                stall_left  = HOLD_CYCLES - 1;
            end else begin
                span = idle_span(rx_tight);
                if (span > 0) begin
                    i_out_ready = 1'b0;
                    stall_left  = span - 1;
                end else begin
                    i_out_ready = 1'b1;
                end
            end
        end
    end

    function automatic logic signed [CW-1:0] rand_coord();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       return CW'(COORD_MAX);
                1:       return CW'(COORD_MIN);
                2:       return '0;
                default: return '1;
            endcase
        end
        return CW'($urandom());
    endfunction

    function automatic t_waypoint random_point();
        t_waypoint p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        return p;
    endfunction

    // Places a measured position relative to the waypoint currently targeted.
    function automatic t_waypoint tick_position(t_aim aim);
        t_waypoint tgt;
        t_waypoint p;
        longint    r;
        longint    h;
        int        axis;
        longint    off [3];
        tgt  = tracker.wp_table[tracker.cur_idx];
        r    = tracker.radius;
        h    = r / 2;
        off  = '{0, 0, 0};
        axis = $urandom_range(0, 2);
        case (aim)
            AIM_NEAR:     foreach (off[i]) off[i] = longint'($urandom_range(0, 2 * h)) - h;
            AIM_EDGE_IN:  off[axis] = $urandom_range(0, 1) ? r - 1 : 1 - r;
            AIM_EDGE_OUT: off[axis] = $urandom_range(0, 1) ? r : -r;
            AIM_LOCAL:
                foreach (off[i]) off[i] = longint'($urandom_range(0, 4 * r + 2)) - 2 * r - 1;
            default:      return random_point();
        endcase
        p.x = CW'(longint'(tgt.x) + off[0]);
        p.y = CW'(longint'(tgt.y) + off[1]);
        p.z = CW'(longint'(tgt.z) + off[2]);
        return p;
    endfunction

    // Offers one beat, holds it until it is taken, then idles for gap cycles.
    task automatic send_beat(t_mode mode, logic [IW-1:0] slot, t_waypoint pos, int gap);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_mode     = mode;
        i_slot     = slot;
        i_coord_x  = pos.x;
        i_coord_y  = pos.y;
        i_coord_z  = pos.z;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_beat(mode, slot, pos);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_wp(int slot, int x, int y, int z);
        t_waypoint p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.z = CW'(z);
        send_beat(MODE_LOAD, IW'(slot), p, idle_span(tx_tight));
    endtask

    task automatic tick_at(int x, int y, int z);
        t_waypoint p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.z = CW'(z);
        send_beat(MODE_TICK, IW'($urandom_range(0, NWP - 1)), p, idle_span(tx_tight));
    endtask

    task automatic tick_aimed(t_aim aim);
        send_beat(MODE_TICK, IW'($urandom_range(0, NWP - 1)), tick_position(aim),
                  idle_span(tx_tight));
    endtask

    // Lets every outstanding command come back, then a few quiet cycles for
    // any tick that produces nothing.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg idx, int data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = CFG_DATA_W'(data);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // New settings for a random phase, with the extremes well represented.
    task automatic pick_settings();
        int r;
        if ($urandom_range(0, 99) < 85) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       cfg_write(CFG_ARRIVE_RADIUS, 0);
                1:       cfg_write(CFG_ARRIVE_RADIUS, 65535);
                2:       cfg_write(CFG_ARRIVE_RADIUS, 1);
                3, 4, 5: cfg_write(CFG_ARRIVE_RADIUS, $urandom_range(100, 2000));
                default: cfg_write(CFG_ARRIVE_RADIUS, $urandom_range(0, 65535));
            endcase
        end
        if ($urandom_range(0, 99) < 85) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                cfg_write(CFG_ROUTE_LENGTH, NWP);
            else if (r < 65)
                cfg_write(CFG_ROUTE_LENGTH, $urandom_range(NWP + 1, 127));
            else if (r < 82)
                cfg_write(CFG_ROUTE_LENGTH, tracker.cur_idx + 1);
            else if (r < 92)
                cfg_write(CFG_ROUTE_LENGTH, $urandom_range(0, tracker.cur_idx));
            else
                cfg_write(CFG_ROUTE_LENGTH, $urandom_range(0, NWP));
        end
    endtask

    initial begin : stimulus
        int        sent;
        int        phase_len;
        int        slot;
        int        r;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_ARRIVE_RADIUS;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_LOAD;
        i_slot      = '0;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_coord_z   = '0;
        i_out_ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening. A tick on an empty route gives nothing.
        tick_at(0, 0, 0);
        load_wp(0, 0, 0, 0);
        load_wp(1, COORD_MAX, COORD_MAX, COORD_MAX);
        load_wp(2, COORD_MIN, COORD_MIN, COORD_MIN);
        load_wp(3, 1000, -1000, 500);
        load_wp(4, 0, 0, 0);
        load_wp(63, -1, 2796202, 5592405);
        wait_drained();
        cfg_write(CFG_ROUTE_LENGTH, 4);
        cfg_write(CFG_ARRIVE_RADIUS, 0);
        // A zero radius is never reached, even on the waypoint itself.
        tick_at(0, 0, 0);
        wait_drained();
        cfg_write(CFG_ARRIVE_RADIUS, 100);
        // Exactly on the radius is outside; one millimetre closer is inside.
        tick_at(100, 0, 0);
        tick_at(99, 0, 0);
        // Far beyond 16 bits on every axis, then exactly on the waypoint.
        tick_at(COORD_MIN, COORD_MIN, COORD_MIN);
        tick_at(COORD_MAX, COORD_MAX, COORD_MAX);
        wait_drained();
        cfg_write(CFG_ARRIVE_RADIUS, 65535);
        // Largest radius: a full radius on one axis stays outside, while a
        // sum of squares just under the squared radius is inside.
        tick_at(COORD_MIN + 65535, COORD_MIN, COORD_MIN);
        tick_at(COORD_MIN + 37836, COORD_MIN + 37836, COORD_MIN + 37836);
        // First arrival at the last waypoint sets the done flag, then landing.
        tick_at(0, 0, 0);
        tick_at(0, 0, 0);
        // Rewriting the waypoint being landed on moves the landing point.
        load_wp(3, -5, -6, -7);
        tick_at(0, 0, 0);
        wait_drained();
        // Route shortened below the current index: ticks are silent.
        cfg_write(CFG_ROUTE_LENGTH, 2);
        tick_at(0, 0, 0);
        wait_drained();

        // Fill the whole table so that any route length is safe to use.
        for (int s = 0; s < NWP; s++) begin
            send_beat(MODE_LOAD, IW'(s), random_point(), idle_span(tx_tight));
        end
        wait_drained();
        // A route length beyond the table is clipped; the done flag stays set
        // while the index is no longer the last one.
        cfg_write(CFG_ROUTE_LENGTH, 127);
        tick_aimed(AIM_EDGE_OUT);
        tick_aimed(AIM_NEAR);

        // Random phases, each under fresh settings and idling behaviour.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            wait_drained();
            pick_settings();
            tx_tight  = ($urandom_range(0, 3) == 0);
            rx_tight  = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 100);
            for (int n = 0; n < phase_len && sent < RANDOM_BEATS; n++) begin
                if ($urandom_range(0, 99) < 22) begin
                    // Loads often hit the live target or the one after it.
                    if ($urandom_range(0, 99) < 30)
                        slot = tracker.cur_idx + $urandom_range(0, 1);
                    else
                        slot = $urandom_range(0, NWP - 1);
                    if (slot >= NWP) slot = NWP - 1;
                    send_beat(MODE_LOAD, IW'(slot), random_point(), idle_span(tx_tight));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 5)       tick_aimed(AIM_NEAR);
                    else if (r < 8)  tick_aimed(AIM_EDGE_IN);
                    else if (r < 11) tick_aimed(AIM_EDGE_OUT);
                    else if (r < 55) tick_aimed(AIM_LOCAL);
                    else             tick_aimed(AIM_WILD);
                end
                sent++;
            end
        end
        tx_tight = 0;
        rx_tight = 0;
        wait_drained();

        $display("Covered %0d waypoint loads and %0d ticks; %0d commands checked, %0d landing.",
                 tracker.loads, tracker.ticks, tracker.checked, tracker.landings);
        $display("Route index ended at %0d with the done flag %0s.",
                 tracker.cur_idx, tracker.done_flag ? "set" : "clear");
        if (tracker.errors == 0 && tracker.pending_cmds.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
